>>> rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg - shared types and constants for the JSON string unescaper
// Mode and status codes, the result entry, and the byte decode helpers.
// ----------------------------------------------------------------------------
package jsu_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_STR  = 2'd1,
      MODE_ESC  = 2'd2,
      MODE_HEX  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_DATA = 2'd0,
      ST_DONE = 2'd1,
      ST_ERR  = 2'd2
   } status_type;

   typedef struct packed {
      logic       last;
      status_type status;
      logic [7:0] data;
   } entry_type;

   localparam logic [7:0] CHR_QUOTE = 8'h22;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_SLASH = 8'h2F;
   localparam logic [7:0] CHR_LOW_B = 8'h62;
   localparam logic [7:0] CHR_LOW_F = 8'h66;
   localparam logic [7:0] CHR_LOW_N = 8'h6E;
   localparam logic [7:0] CHR_LOW_R = 8'h72;
   localparam logic [7:0] CHR_LOW_T = 8'h74;
   localparam logic [7:0] CHR_LOW_U = 8'h75;

   localparam logic [7:0] CTL_BS = 8'h08;
   localparam logic [7:0] CTL_FF = 8'h0C;
   localparam logic [7:0] CTL_LF = 8'h0A;
   localparam logic [7:0] CTL_CR = 8'h0D;
   localparam logic [7:0] CTL_HT = 8'h09;

   // result queue: 8 entries, room for one full three-byte burst checked
   localparam int FifoDepth = 8;
   localparam int PtrW      = 3;
   localparam int CntW      = 4;
   localparam int MaxBurst  = 3;

   // {valid, digit}; valid low when the byte is not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   // {valid, byte} for single-byte escapes
   function automatic logic [8:0] esc_value(input logic [7:0] b);
      logic [8:0] r;
      case (b)
         CHR_QUOTE:  r = {1'b1, CHR_QUOTE};
         CHR_BSLASH: r = {1'b1, CHR_BSLASH};
         CHR_SLASH:  r = {1'b1, CHR_SLASH};
         CHR_LOW_B:  r = {1'b1, CTL_BS};
         CHR_LOW_F:  r = {1'b1, CTL_FF};
         CHR_LOW_N:  r = {1'b1, CTL_LF};
         CHR_LOW_R:  r = {1'b1, CTL_CR};
         CHR_LOW_T:  r = {1'b1, CTL_HT};
         default:    r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape - streaming JSON string unescaper with UTF-8 output
// Decodes one quoted string per run; escapes and \u code points resolved.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries raw string text, one byte per beat, starting with the
//   opening quote. rsp_* carries results: rsp_tdata is the decoded byte,
//   rsp_tuser the status (data, string done, error), rsp_tlast marks the
//   final result caused by one input beat.
//   Each input byte is decoded in the cycle it is accepted and its zero to
//   three results land in an 8-entry result queue; they appear on rsp_*
//   from the registered queue, behind any older results still waiting.
//   Throughput: one input beat per cycle while req_tready is high. The queue
//   drains one result per cycle while rsp_tready is high; req_tready is
//   taken from the registered queue count alone and drops only while fewer
//   than three free slots remain, which only a receiver stall causes.
//   When the receiver stalls, results wait in the queue in order; once it
//   is nearly full, input is held off until room frees up.
//   Reset (synchronous, active high) empties the queue and returns the
//   decoder to idle, awaiting an opening quote.
// ----------------------------------------------------------------------------
module json_string_unescape
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] status
   output logic       rsp_tlast    // last
);

   // decoder state
   mode_type     mode_ff, mode_in;
   logic [1:0]   hex_count_ff, hex_count_in;
   logic [15:0]  code_point_ff, code_point_in;

   // result queue
   entry_type        fifo_mem [FifoDepth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   logic       req_fire, rsp_fire;
   logic [1:0] burst_n;              // results made by this beat, 0..3
   entry_type  slot [MaxBurst];

   logic [4:0]  hex_d;
   logic [8:0]  esc_d;
   logic [15:0] cp_new;

   assign req_tready = (count_ff <= CntW'(FifoDepth - MaxBurst));
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_fire   = rsp_tvalid & rsp_tready;

   assign rsp_tdata = fifo_mem[rd_ptr_ff].data;
   assign rsp_tuser = fifo_mem[rd_ptr_ff].status;
   assign rsp_tlast = fifo_mem[rd_ptr_ff].last;

   assign hex_d  = hex_value(req_tdata);
   assign esc_d  = esc_value(req_tdata);
   assign cp_new = {code_point_ff[11:0], hex_d[3:0]};

   // byte decode: next state and the burst of results
   always_comb begin
      mode_in       = mode_ff;
      hex_count_in  = hex_count_ff;
      code_point_in = code_point_ff;
      burst_n       = 2'd0;
      for (int i = 0; i < MaxBurst; i++) begin
         slot[i] = '{last: 1'b1, status: ST_DATA, data: 8'h00};
      end
      case (mode_ff)
         MODE_IDLE: begin
            if (req_tdata == CHR_QUOTE) begin
               mode_in = MODE_STR;
            end else begin
               burst_n    = 2'd1;
               slot[0]    = '{last: 1'b1, status: ST_ERR, data: 8'h00};
            end
         end
         MODE_STR: begin
            if (req_tdata == CHR_QUOTE) begin
               mode_in = MODE_IDLE;
               burst_n = 2'd1;
               slot[0] = '{last: 1'b1, status: ST_DONE, data: 8'h00};
            end else if (req_tdata == CHR_BSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               burst_n = 2'd1;
               slot[0] = '{last: 1'b1, status: ST_DATA, data: req_tdata};
            end
         end
         MODE_ESC: begin
            if (req_tdata == CHR_LOW_U) begin
               mode_in       = MODE_HEX;
               hex_count_in  = 2'd0;
               code_point_in = 16'h0000;
            end else if (esc_d[8]) begin
               mode_in = MODE_STR;
               burst_n = 2'd1;
               slot[0] = '{last: 1'b1, status: ST_DATA, data: esc_d[7:0]};
            end else begin
               mode_in       = MODE_IDLE;
               hex_count_in  = 2'd0;
               code_point_in = 16'h0000;
               burst_n       = 2'd1;
               slot[0]       = '{last: 1'b1, status: ST_ERR, data: 8'h00};
            end
         end
         MODE_HEX: begin
            if (!hex_d[4]) begin
               // bad hex digit drops the collected code point
               mode_in       = MODE_IDLE;
               hex_count_in  = 2'd0;
               code_point_in = 16'h0000;
               burst_n       = 2'd1;
               slot[0]       = '{last: 1'b1, status: ST_ERR, data: 8'h00};
            end else begin
               code_point_in = cp_new;
               if (hex_count_ff == 2'd3) begin
                  hex_count_in = 2'd0;
                  mode_in      = MODE_STR;
                  if (cp_new[15:7] == '0) begin
                     burst_n = 2'd1;
                     slot[0] = '{last: 1'b1, status: ST_DATA,
                                 data: {1'b0, cp_new[6:0]}};
                  end else if (cp_new[15:11] == '0) begin
                     burst_n = 2'd2;
                     slot[0] = '{last: 1'b0, status: ST_DATA,
                                 data: {3'b110, cp_new[10:6]}};
                     slot[1] = '{last: 1'b1, status: ST_DATA,
                                 data: {2'b10, cp_new[5:0]}};
                  end else begin
                     burst_n = 2'd3;
                     slot[0] = '{last: 1'b0, status: ST_DATA,
                                 data: {4'b1110, cp_new[15:12]}};
                     slot[1] = '{last: 1'b0, status: ST_DATA,
                                 data: {2'b10, cp_new[11:6]}};
                     slot[2] = '{last: 1'b1, status: ST_DATA,
                                 data: {2'b10, cp_new[5:0]}};
                  end
               end else begin
                  hex_count_in = hex_count_ff + 2'd1;
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase
   end

   // queue pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + PtrW'(burst_n);
         count_in  = count_in + CntW'(burst_n);
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + PtrW'(1);
         count_in  = count_in - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         hex_count_ff  <= 2'd0;
         code_point_ff <= 16'h0000;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (req_fire) begin
            mode_ff       <= mode_in;
            hex_count_ff  <= hex_count_in;
            code_point_ff <= code_point_in;
         end
      end
   end

   // queue storage, burst written at consecutive slots
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < MaxBurst; i++) begin
            if (2'(i) < burst_n) begin
               fifo_mem[wr_ptr_ff + PtrW'(i)] <= slot[i];
            end
         end
      end
   end

endmodule
